>>> src/sqtpi_pkg.sv
// ----------------------------------------------------------------------------
// sqtpi_pkg
// Shared types, constants and helpers of the QR reduction tree index unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sqtpi_pkg;

  localparam int MAX_ROWS  = 1024;
  localparam int CFG_W     = 11;
  localparam int ROW_W     = 10;
  localparam int PQ_W      = 21;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;
  localparam int DIVCNT_W  = 5;

  localparam logic [DIVCNT_W-1:0] DIV_LONG_STEPS   = 5'd21;
  localparam logic [DIVCNT_W-1:0] DIV_NARROW_STEPS = 5'd11;

  typedef enum logic [1:0] {
    LVL_TS    = 2'd0,
    LVL_LOCAL = 2'd1,
    LVL_DIST  = 2'd3
  } lvl_t;

  localparam logic [1:0] ROW_TYPE_DIST = 2'd2;

  typedef enum logic [1:0] {
    CFG_TOP  = 2'd0,
    CFG_MID  = 2'd1,
    CFG_ROWS = 2'd2
  } cfg_idx_t;

  localparam logic KIND_NEXT = 1'b0;
  localparam logic KIND_PREV = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_ROW,
    ST_DIV_START,
    ST_DIV_PIV,
    ST_DIV_WRAP,
    ST_DIV_OVER,
    ST_EVAL
  } back_state_t;

  typedef struct packed {
    logic             kind;
    logic [ROW_W-1:0] step_k;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] pivot;
    logic [CFG_W-1:0] start_req;
    lvl_t             lvl_row;
    lvl_t             lvl_start;
    lvl_t             lvl_pivot;
  } q_entry_t;

  typedef struct packed {
    logic [1:0]       row_type;
    logic [CFG_W-1:0] row_killer;
    logic [CFG_W-1:0] panel_pivots;
    logic [CFG_W-1:0] found_row;
    logic             query_error;
  } result_t;

  typedef struct packed {
    logic            start;
    logic            narrow;
    logic [PQ_W-1:0] dividend;
    logic [PQ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [PQ_W-1:0] rem;
  } div_rsp_t;

  function automatic lvl_t lvl_of(input logic [ROW_W-1:0] k, input logic [CFG_W-1:0] m,
                                  input logic [CFG_W-1:0] p, input logic [PQ_W-1:0] pq);
    logic [PQ_W:0] mm;
    lvl_t          lv;
    mm = {{(PQ_W-CFG_W+1){1'b0}}, m};
    if (mm >= ({{(PQ_W-ROW_W+1){1'b0}}, k} + {1'b0, pq})) begin
      lv = LVL_TS;
    end else if (mm >= ({{(PQ_W-ROW_W+1){1'b0}}, k} + {{(PQ_W-CFG_W+1){1'b0}}, p})) begin
      lv = LVL_LOCAL;
    end else begin
      lv = LVL_DIST;
    end
    return lv;
  endfunction

endpackage

`default_nettype wire

>>> src/sqtpi_if.sv
// ----------------------------------------------------------------------------
// sqtpi_if
// Valid/ready channels carrying query beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface sqtpi_in_if import sqtpi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ROW_W-1:0] step_k;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] pivot;
  logic [CFG_W-1:0] start_req;

  modport source (output valid, kind, step_k, row, pivot, start_req, input ready);
  modport sink (input valid, kind, step_k, row, pivot, start_req, output ready);
endinterface

interface sqtpi_out_if import sqtpi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       row_type;
  logic [CFG_W-1:0] row_killer;
  logic [CFG_W-1:0] panel_pivots;
  logic [CFG_W-1:0] found_row;
  logic             query_error;

  modport source (output valid, row_type, row_killer, panel_pivots, found_row, query_error,
                  input ready);
  modport sink (input valid, row_type, row_killer, panel_pivots, found_row, query_error,
                output ready);
endinterface

`default_nettype wire

>>> src/systolic_qr_tree_pivot_index.sv
// Queries are searched one at a time by the shared remainder unit, which
// resolves one quotient bit per cycle for each of two or five remainders; the
// two-entry queue lets new queries be accepted while one is being searched.
// Reset: synchronous, active low; clears the queue, sequencer and output
// valid, and sets all three size registers to one.
// ----------------------------------------------------------------------------
// systolic_qr_tree_pivot_index
// Index unit of a three-level reduction tree for tiled QR factorization.
// ----------------------------------------------------------------------------
`default_nettype none

module systolic_qr_tree_pivot_index import sqtpi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  sqtpi_in_if.sink              in_item,
  sqtpi_out_if.source           out_result
);

  logic [CFG_W-1:0] top_r, top_nxt;
  logic [CFG_W-1:0] mid_r, mid_nxt;
  logic [CFG_W-1:0] rows_r, rows_nxt;
  logic [CFG_W-1:0] wdata_sat;
  logic [CFG_W-1:0] p_eff, p_eff_nxt, q_eff_nxt;
  logic [PQ_W-1:0]  pq_r;
  logic [2*CFG_W-1:0] pq_prod;
  logic             push;
  q_entry_t         push_data;
  logic             pop;
  q_entry_t         head;
  logic             q_full;
  logic             q_empty;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign wdata_sat = (cfg_wdata > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : cfg_wdata;

  always_comb begin
    top_nxt  = top_r;
    mid_nxt  = mid_r;
    rows_nxt = rows_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TOP:  top_nxt  = wdata_sat;
        CFG_MID:  mid_nxt  = wdata_sat;
        CFG_ROWS: rows_nxt = wdata_sat;
        default:  rows_nxt = rows_r;
      endcase
    end
  end

  assign p_eff     = (top_r == '0) ? CFG_W'(1) : top_r;
  assign p_eff_nxt = (top_nxt == '0) ? CFG_W'(1) : top_nxt;
  assign q_eff_nxt = (mid_nxt == '0) ? CFG_W'(1) : mid_nxt;
  assign pq_prod   = p_eff_nxt * q_eff_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r  <= CFG_W'(1);
      mid_r  <= CFG_W'(1);
      rows_r <= CFG_W'(1);
      pq_r   <= PQ_W'(1);
    end else begin
      top_r  <= top_nxt;
      mid_r  <= mid_nxt;
      rows_r <= rows_nxt;
      pq_r   <= pq_prod[PQ_W-1:0];
    end
  end

  sqtpi_front u_front (
    .in_item   (in_item),
    .p_eff     (p_eff),
    .pq        (pq_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  sqtpi_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  sqtpi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sqtpi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .p_eff      (p_eff),
    .pq         (pq_r),
    .mt         (rows_r),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_result (out_result)
  );

`ifndef SYNTHESIS
  a_pq_nonzero: assert property (@(posedge clk) disable iff (!rst_n) pq_r != '0)
    else $error("tree product is zero");

  a_err_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_result.valid && out_result.query_error |-> out_result.found_row == rows_r)
    else $error("failed search does not answer tile_rows");

  a_npiv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_result.valid |-> out_result.panel_pivots <= rows_r)
    else $error("panel pivot count exceeds tile rows");

  a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

>>> src/sqtpi_fifo.sv
// ----------------------------------------------------------------------------
// sqtpi_fifo
// Two-entry queue decoupling the classifying front from the search back.
// ----------------------------------------------------------------------------
`default_nettype none

module sqtpi_fifo import sqtpi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  input  wire logic     pop,
  output q_entry_t      head,
  output logic          full,
  output logic          empty
);

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> src/sqtpi_front.sv
// ----------------------------------------------------------------------------
// sqtpi_front
// Accepts query beats and classifies row, start and pivot into tree levels.
// ----------------------------------------------------------------------------
`default_nettype none

module sqtpi_front import sqtpi_pkg::*; (
  sqtpi_in_if.sink             in_item,
  input  wire logic [CFG_W-1:0] p_eff,
  input  wire logic [PQ_W-1:0]  pq,
  input  wire logic             q_full,
  output logic                  push,
  output q_entry_t              push_data
);

  assign in_item.ready = !q_full;
  assign push          = in_item.valid && !q_full;

  always_comb begin
    push_data.kind      = in_item.kind;
    push_data.step_k    = in_item.step_k;
    push_data.row       = in_item.row;
    push_data.pivot     = in_item.pivot;
    push_data.start_req = in_item.start_req;
    push_data.lvl_row   = lvl_of(in_item.step_k, {1'b0, in_item.row}, p_eff, pq);
    push_data.lvl_start = lvl_of(in_item.step_k, in_item.start_req, p_eff, pq);
    push_data.lvl_pivot = lvl_of(in_item.step_k, {1'b0, in_item.pivot}, p_eff, pq);
  end

endmodule

`default_nettype wire

>>> src/sqtpi_div.sv
// ----------------------------------------------------------------------------
// sqtpi_div
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sqtpi_div import sqtpi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                busy_r;
  logic                done_r;
  logic [DIVCNT_W-1:0] cnt_r;
  logic [PQ_W-1:0]     rem_r;
  logic [PQ_W-1:0]     dvd_r;
  logic [PQ_W-1:0]     dvs_r;
  logic [PQ_W:0]       trial;
  logic                ge;

  assign trial = {rem_r, dvd_r[PQ_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.narrow ? DIV_NARROW_STEPS : DIV_LONG_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIVCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvs_r <= req.divisor;
      dvd_r <= req.narrow ? {req.dividend[CFG_W-1:0], {(PQ_W-CFG_W){1'b0}}} : req.dividend;
    end else if (busy_r) begin
      rem_r <= ge ? PQ_W'(trial - {1'b0, dvs_r}) : trial[PQ_W-1:0];
      dvd_r <= {dvd_r[PQ_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> src/sqtpi_back.sv
// ----------------------------------------------------------------------------
// sqtpi_back
// Sequences the remainders of one query and resolves the fall-through search.
// ----------------------------------------------------------------------------
`default_nettype none

module sqtpi_back import sqtpi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CFG_W-1:0] p_eff,
  input  wire logic [PQ_W-1:0]  pq,
  input  wire logic [CFG_W-1:0] mt,
  input  wire q_entry_t         head,
  input  wire logic             q_empty,
  output logic                  pop,
  output div_req_t              div_req,
  input  wire div_rsp_t         div_rsp,
  sqtpi_out_if.source           out_result
);

  back_state_t      state_r;
  back_state_t      state_nxt;
  logic             launched_r;
  q_entry_t         item_r;
  logic [CFG_W-1:0] rem_row_r;
  logic [CFG_W-1:0] rem_start_r;
  logic [CFG_W-1:0] rem_piv_r;
  logic [CFG_W-1:0] rem_wrap_r;
  logic [CFG_W-1:0] rem_over_r;
  logic             out_valid_r;
  result_t          res_r;
  result_t          res_nxt;
  logic             out_load;
  logic [PQ_W+1:0]  dvd_calc;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_DIV_ROW;
        end
      end
      ST_DIV_ROW: begin
        if (div_rsp.done) begin
          state_nxt = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        if (div_rsp.done) begin
          state_nxt = (item_r.kind == KIND_NEXT) ? ST_EVAL : ST_DIV_PIV;
        end
      end
      ST_DIV_PIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_DIV_WRAP;
        end
      end
      ST_DIV_WRAP: begin
        if (div_rsp.done) begin
          state_nxt = ST_DIV_OVER;
        end
      end
      ST_DIV_OVER: begin
        if (div_rsp.done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!out_valid_r || out_result.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop            = 1'b0;
    out_load       = 1'b0;
    div_req.start  = 1'b0;
    div_req.narrow = 1'b1;
    div_req.divisor = pq;
    dvd_calc       = '0;
    case (state_r)
      ST_IDLE: begin
        pop = !q_empty;
      end
      ST_DIV_ROW: begin
        div_req.start = !launched_r;
        dvd_calc = (PQ_W+2)'(item_r.row) - (PQ_W+2)'(item_r.step_k);
        if (item_r.lvl_row != LVL_TS) begin
          div_req.divisor = PQ_W'(p_eff);
        end
      end
      ST_DIV_START: begin
        div_req.start = !launched_r;
        dvd_calc = (PQ_W+2)'(item_r.start_req) - (PQ_W+2)'(item_r.step_k);
        if (item_r.lvl_start != LVL_TS) begin
          div_req.divisor = PQ_W'(p_eff);
        end
      end
      ST_DIV_PIV: begin
        div_req.start = !launched_r;
        dvd_calc = (PQ_W+2)'(item_r.pivot);
      end
      ST_DIV_WRAP: begin
        div_req.start = !launched_r;
        dvd_calc = (PQ_W+2)'(mt) - (PQ_W+2)'(rem_piv_r) - 1'b1;
      end
      ST_DIV_OVER: begin
        div_req.start   = !launched_r;
        div_req.narrow  = 1'b0;
        div_req.divisor = PQ_W'(p_eff);
        dvd_calc = (PQ_W+2)'(item_r.pivot) + (PQ_W+2)'(pq) - (PQ_W+2)'(p_eff)
                   - (PQ_W+2)'(mt);
      end
      ST_EVAL: begin
        out_load = !out_valid_r || out_result.ready;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
    div_req.dividend = dvd_calc[PQ_W-1:0];
  end

  always_comb begin : eval_logic
    logic signed [23:0] vk, vpiv, vst, vp, vpq, vmt, vks, nx, cur, found, npiv;
    logic               fin, err;
    lvl_t               lvc;
    vk    = $signed({14'b0, item_r.step_k});
    vpiv  = $signed({14'b0, item_r.pivot});
    vst   = $signed({13'b0, item_r.start_req});
    vp    = $signed({13'b0, p_eff});
    vpq   = $signed({3'b0, pq});
    vmt   = $signed({13'b0, mt});
    vks   = (item_r.lvl_start == LVL_DIST) ? vk : vk + $signed({13'b0, rem_start_r});
    found = vmt;
    nx    = vmt;
    cur   = vst;
    fin   = 1'b0;
    err   = 1'b0;
    lvc   = item_r.lvl_start;
    if (item_r.kind == KIND_NEXT) begin
      if (!(vst > vpiv && vpiv >= vk) || !(vst == vmt || vpiv == vks)) begin
        err = 1'b1;
      end else begin
        if (!(vst < vmt)) begin
          if (item_r.lvl_pivot == LVL_TS) begin
            fin = 1'b1;
            if (cur != vmt) begin
              err = 1'b1;
            end
          end else begin
            lvc = LVL_TS;
          end
        end
        if (!fin && lvc == LVL_TS) begin
          nx = ((cur == vmt) ? vpiv : cur) + vpq;
          if (nx < vmt) begin
            found = nx;
            fin   = 1'b1;
          end else begin
            cur = vmt;
            lvc = LVL_LOCAL;
          end
        end
        if (!fin && lvc == LVL_LOCAL) begin
          if (item_r.lvl_pivot != LVL_DIST) begin
            found = vmt;
            fin   = 1'b1;
          end else begin
            nx = ((cur == vmt) ? vpiv : cur) + vp;
            if (nx >= vk + vp && nx < vk + vpq && nx < vmt) begin
              found = nx;
              fin   = 1'b1;
            end else begin
              cur = vmt;
            end
          end
        end
        if (!fin) begin
          if (vpiv > vk) begin
            found = vmt;
          end else begin
            nx    = ((cur == vmt) ? vpiv : cur) + 24'sd1;
            found = (nx < vk + vp) ? nx : vmt;
          end
        end
      end
    end else begin
      if (!(vst >= vpiv && vpiv >= vk && vst < vmt) || !(vst == vpiv || vpiv == vks)) begin
        err = 1'b1;
      end else if (item_r.lvl_pivot == LVL_TS) begin
        found = vmt;
      end else if (item_r.lvl_pivot < item_r.lvl_start) begin
        err = 1'b1;
      end else begin
        if (lvc == LVL_DIST) begin
          if (vpiv == vk) begin
            if (cur == vpiv) begin
              nx = cur + vp - 24'sd1;
              if (nx >= vmt) begin
                nx = (vmt - 24'sd1 > vpiv) ? vmt - 24'sd1 : vpiv;
              end
            end else begin
              nx = cur - 24'sd1;
            end
            if (vpiv < nx && nx < vk + vp) begin
              found = nx;
              fin   = 1'b1;
            end
          end
          cur = vpiv;
          lvc = LVL_LOCAL;
        end
        if (!fin && lvc == LVL_LOCAL) begin
          if (item_r.lvl_pivot == LVL_DIST) begin
            if (cur == vpiv) begin
              nx = cur + vpq - vp;
              if (vpiv < nx && nx >= vmt) begin
                nx = vmt - vp + $signed({13'b0, rem_over_r});
              end
            end else begin
              nx = cur - vp;
            end
            if (vpiv < nx && nx < vk + vpq) begin
              found = nx;
              fin   = 1'b1;
            end
          end
          cur = vpiv;
        end
        if (!fin) begin
          nx = (cur == vpiv) ? vmt - $signed({13'b0, rem_wrap_r}) - 24'sd1 : cur - vpq;
          if (vpiv < nx) begin
            found = nx;
          end
        end
      end
    end
    npiv = vmt - vk;
    if (npiv < 24'sd0) begin
      npiv = 24'sd0;
    end
    if (npiv > vpq) begin
      npiv = vpq;
    end
    res_nxt.row_type     = (item_r.lvl_row == LVL_DIST) ? ROW_TYPE_DIST : item_r.lvl_row;
    res_nxt.row_killer   = (item_r.lvl_row == LVL_DIST) ? CFG_W'(item_r.step_k)
                           : CFG_W'(item_r.step_k) + rem_row_r;
    res_nxt.panel_pivots = npiv[CFG_W-1:0];
    res_nxt.found_row    = err ? mt : found[CFG_W-1:0];
    res_nxt.query_error  = err;
  end

  assign out_result.valid        = out_valid_r;
  assign out_result.row_type     = res_r.row_type;
  assign out_result.row_killer   = res_r.row_killer;
  assign out_result.panel_pivots = res_r.panel_pivots;
  assign out_result.found_row    = res_r.found_row;
  assign out_result.query_error  = res_r.query_error;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (div_req.start) begin
        launched_r <= 1'b1;
      end else if (div_rsp.done) begin
        launched_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_result.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head;
    end
    if (out_load) begin
      res_r <= res_nxt;
    end
    if (div_rsp.done) begin
      case (state_r)
        ST_DIV_ROW:   rem_row_r   <= div_rsp.rem[CFG_W-1:0];
        ST_DIV_START: rem_start_r <= div_rsp.rem[CFG_W-1:0];
        ST_DIV_PIV:   rem_piv_r   <= div_rsp.rem[CFG_W-1:0];
        ST_DIV_WRAP:  rem_wrap_r  <= div_rsp.rem[CFG_W-1:0];
        ST_DIV_OVER:  rem_over_r  <= div_rsp.rem[CFG_W-1:0];
        default:      rem_over_r  <= rem_over_r;
      endcase
    end
  end

endmodule

`default_nettype wire
